// ===== rtl/iatc_pkg.sv =====
// Package for the address text classifier: types, character codes and group checks.
package iatc_pkg;

  // Class codes for one finished string
  typedef enum logic [1:0] {
    CLS_NONE = 2'd0,
    CLS_IPV4 = 2'd1,
    CLS_IPV6 = 2'd2
  } addr_class_e;

  // ASCII codes used by the character decode
  localparam logic [7:0] CHAR_DOT     = 8'h2E;
  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_LOW_A   = 8'h61;
  localparam logic [7:0] CHAR_LOW_F   = 8'h66;
  localparam logic [7:0] CHAR_UP_A    = 8'h41;
  localparam logic [7:0] CHAR_UP_F    = 8'h46;

  // Limits of the two readings
  localparam logic [9:0] OCTET_MAX     = 10'd255;
  localparam logic [9:0] VALUE_SAT     = 10'd256;
  localparam logic [2:0] LEN_SAT       = 3'd7;
  localparam logic [2:0] DEC_LEN_MAX   = 3'd3;
  localparam logic [2:0] HEX_LEN_MAX   = 3'd4;
  localparam logic [3:0] DEC_GROUPS    = 4'd4;
  localparam logic [3:0] DEC_SEPS      = 4'd3;
  localparam logic [3:0] HEX_GROUPS    = 4'd8;
  localparam logic [3:0] HEX_SEPS      = 4'd7;
  localparam logic [3:0] COUNT_SAT     = 4'd15;

  // Running tallies for one string
  typedef struct packed {
    logic       at_start;
    logic       seen_dot;
    logic       seen_colon;
    logic       decimal_ok;
    logic       hex_ok;
    logic [2:0] group_length;
    logic       group_leading_zero;
    logic [9:0] group_value;
    logic [3:0] good_decimal_groups;
    logic [3:0] good_hex_groups;
    logic [3:0] separator_count;
  } tally_t;

  localparam tally_t TALLY_RESET = '{
    at_start:            1'b1,
    seen_dot:            1'b0,
    seen_colon:          1'b0,
    decimal_ok:          1'b1,
    hex_ok:              1'b1,
    group_length:        3'd0,
    group_leading_zero:  1'b0,
    group_value:         10'd0,
    good_decimal_groups: 4'd0,
    good_hex_groups:     4'd0,
    separator_count:     4'd0
  };

  function automatic logic [3:0] sat_inc(input logic [3:0] v);
    return (v < COUNT_SAT) ? 4'(v + 4'd1) : COUNT_SAT;
  endfunction

  // Decimal group: 1..3 digits, no leading zero on multi-digit, value <= 255
  function automatic logic dec_group_good(input tally_t t);
    return (t.group_length >= 3'd1) && (t.group_length <= DEC_LEN_MAX) &&
           !((t.group_length >= 3'd2) && t.group_leading_zero) &&
           (t.group_value <= OCTET_MAX);
  endfunction

  // Hex group: 1..4 digits
  function automatic logic hex_group_good(input tally_t t);
    return (t.group_length >= 3'd1) && (t.group_length <= HEX_LEN_MAX);
  endfunction

endpackage

// ===== rtl/iatc_tally.sv =====
// Per-character tally update and end-of-string classification.
module iatc_tally (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            char_i,
  input  logic                  last_i,
  output iatc_pkg::addr_class_e class_o
);

  iatc_pkg::tally_t tally_q, tally_d;

  logic        is_dot, is_colon, is_digit, is_hex_letter;
  logic [3:0]  digit;
  logic [11:0] value_next;
  logic [3:0]  dec_cnt, hex_cnt;

  // Character decode
  assign is_dot        = (char_i == iatc_pkg::CHAR_DOT);
  assign is_colon      = (char_i == iatc_pkg::CHAR_COLON);
  assign is_digit      = (char_i >= iatc_pkg::CHAR_ZERO) && (char_i <= iatc_pkg::CHAR_NINE);
  assign is_hex_letter = ((char_i >= iatc_pkg::CHAR_LOW_A) && (char_i <= iatc_pkg::CHAR_LOW_F)) ||
                         ((char_i >= iatc_pkg::CHAR_UP_A) && (char_i <= iatc_pkg::CHAR_UP_F));
  assign digit         = 4'(char_i - iatc_pkg::CHAR_ZERO);
  assign value_next    = ({2'b00, tally_q.group_value} * 12'd10) + {8'd0, digit};

  // Next tally
  always_comb begin
    tally_d = tally_q;
    if (is_dot || is_colon) begin
      if (tally_q.at_start) begin
        tally_d.decimal_ok = 1'b0;
        tally_d.hex_ok     = 1'b0;
      end
      if (is_dot) begin
        tally_d.seen_dot = 1'b1;
        if (iatc_pkg::dec_group_good(tally_q)) begin
          tally_d.good_decimal_groups = iatc_pkg::sat_inc(tally_q.good_decimal_groups);
        end
      end else begin
        tally_d.seen_colon = 1'b1;
        if (iatc_pkg::hex_group_good(tally_q)) begin
          tally_d.good_hex_groups = iatc_pkg::sat_inc(tally_q.good_hex_groups);
        end
      end
      tally_d.separator_count    = iatc_pkg::sat_inc(tally_q.separator_count);
      tally_d.group_length       = 3'd0;
      tally_d.group_leading_zero = 1'b0;
      tally_d.group_value        = 10'd0;
    end else if (is_digit || is_hex_letter) begin
      if ((tally_q.group_length == 3'd0) && (char_i == iatc_pkg::CHAR_ZERO)) begin
        tally_d.group_leading_zero = 1'b1;
      end
      if (tally_q.group_length < iatc_pkg::LEN_SAT) begin
        tally_d.group_length = 3'(tally_q.group_length + 3'd1);
      end
      if (is_digit) begin
        tally_d.group_value = (value_next > {2'b00, iatc_pkg::VALUE_SAT}) ?
                              iatc_pkg::VALUE_SAT : value_next[9:0];
      end else begin
        tally_d.decimal_ok = 1'b0;
      end
    end else begin
      tally_d.decimal_ok = 1'b0;
      tally_d.hex_ok     = 1'b0;
    end
    tally_d.at_start = 1'b0;
  end

  // Close the open group and classify
  always_comb begin
    dec_cnt = iatc_pkg::dec_group_good(tally_d) ?
              iatc_pkg::sat_inc(tally_d.good_decimal_groups) : tally_d.good_decimal_groups;
    hex_cnt = iatc_pkg::hex_group_good(tally_d) ?
              iatc_pkg::sat_inc(tally_d.good_hex_groups) : tally_d.good_hex_groups;
    if (tally_d.decimal_ok && tally_d.seen_dot && !tally_d.seen_colon &&
        (dec_cnt == iatc_pkg::DEC_GROUPS) && (tally_d.separator_count == iatc_pkg::DEC_SEPS)) begin
      class_o = iatc_pkg::CLS_IPV4;
    end else if (tally_d.hex_ok && tally_d.seen_colon && !tally_d.seen_dot &&
                 (hex_cnt == iatc_pkg::HEX_GROUPS) &&
                 (tally_d.separator_count == iatc_pkg::HEX_SEPS)) begin
      class_o = iatc_pkg::CLS_IPV6;
    end else begin
      class_o = iatc_pkg::CLS_NONE;
    end
  end

  // Tally registers: back to reset after the last character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tally_q <= iatc_pkg::TALLY_RESET;
    end else if (step_i) begin
      tally_q <= last_i ? iatc_pkg::TALLY_RESET : tally_d;
    end
  end

  // After a last character the next string starts fresh
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && last_i) |=> (tally_q == iatc_pkg::TALLY_RESET))
    else $error("tally not cleared after last character");

  // No separator counted means neither separator kind was seen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tally_q.separator_count == 4'd0) |-> (!tally_q.seen_dot && !tally_q.seen_colon))
    else $error("separator flags without separator count");

  // Good group counts never exceed separators seen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tally_q.good_decimal_groups <= tally_q.separator_count) &&
    (tally_q.good_hex_groups <= tally_q.separator_count))
    else $error("good group count above separator count");

endmodule

// ===== rtl/ip_address_text_classifier_core.sv =====
// Top level of the address text classifier: input register, tally, result register.
// A last character's class is written to the result register when its staged beat steps the tally.
// The block takes one character per cycle while in_stall_o is low.
// The input register is held only while its last-character beat waits on a stalled result.
// Reset (rst_ni low, asynchronous) empties both registers and returns the tally to its
// start-of-string state.
module ip_address_text_classifier_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_code_i,
  input  logic       last_char_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] address_class_o
);

  logic       in_valid_q;
  logic [7:0] char_q;
  logic       last_q;
  logic       out_valid_q;
  logic [1:0] class_q;
  logic       out_free, step, in_take;
  iatc_pkg::addr_class_e class_w;

  // Handshake: the staged beat moves unless it produces a result that cannot land
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && (!last_q || out_free);
  assign in_stall_o = in_valid_q && !step;
  assign in_take    = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      char_q <= char_code_i;
      last_q <= last_char_i;
    end
  end

  iatc_tally u_tally (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .char_i  (char_q),
    .last_i  (last_q),
    .class_o (class_w)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step && last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && last_q) begin
      class_q <= class_w;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign address_class_o = class_q;

  // Stall only ever comes from a staged last character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && last_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked result");

  // A new result beat comes only from a stepped last character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !($past(out_valid_q) && $past(out_stall_i))) |->
      ($past(step) && $past(last_q)))
    else $error("result beat without a last character");

  // Class code 3 never leaves the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (class_q != 2'd3))
    else $error("invalid class code on result");

endmodule

// ===== tb/tb.sv =====
// Testbench for the address text classifier: directed and random strings against a predictor.
`timescale 1ns / 100ps

module tb;

  localparam int CLK_HALF   = 2;
  localparam int RESET_CYC  = 7;
  localparam int RAND_CHARS = 1000;
  localparam int MAX_WAIT   = 16;
  localparam int DRAIN_CYC  = 8;
  localparam int CYCLE_CAP  = 400000;

  // Predicts the class of each finished string and checks the block's results
  class addr_class_tracker;
    bit         at_start;
    bit         seen_dot;
    bit         seen_colon;
    bit         dec_ok;
    bit         hex_ok;
    bit         lead_zero;
    bit [2:0]   grp_len;
    bit [9:0]   grp_val;
    bit [3:0]   dec_groups;
    bit [3:0]   hex_groups;
    bit [3:0]   sep_count;
    iatc_pkg::addr_class_e expected_classes[$];
    int         errors;

    function new();
      errors = 0;
      clear_string();
    endfunction

    function void clear_group();
      grp_len   = 3'd0;
      grp_val   = 10'd0;
      lead_zero = 1'b0;
    endfunction

    function void clear_string();
      at_start   = 1'b1;
      seen_dot   = 1'b0;
      seen_colon = 1'b0;
      dec_ok     = 1'b1;
      hex_ok     = 1'b1;
      dec_groups = 4'd0;
      hex_groups = 4'd0;
      sep_count  = 4'd0;
      clear_group();
    endfunction

    // Saturating tally bump
    function bit [3:0] bump(bit [3:0] v);
      return (v == iatc_pkg::COUNT_SAT) ? v : v + 4'd1;
    endfunction

    function bit octet_ok();
      return grp_len >= 3'd1 && grp_len <= iatc_pkg::DEC_LEN_MAX &&
             !(grp_len >= 3'd2 && lead_zero) && grp_val <= iatc_pkg::OCTET_MAX;
    endfunction

    function bit hextet_ok();
      return grp_len >= 3'd1 && grp_len <= iatc_pkg::HEX_LEN_MAX;
    endfunction

    // One accepted character beat
    function void note_char(logic [7:0] c, logic last);
      bit          is_digit;
      bit          is_letter;
      int          v;
      bit [3:0]    dg;
      bit [3:0]    hg;
      iatc_pkg::addr_class_e cls;
      is_digit  = (c >= iatc_pkg::CHAR_ZERO && c <= iatc_pkg::CHAR_NINE);
      is_letter = (c >= iatc_pkg::CHAR_LOW_A && c <= iatc_pkg::CHAR_LOW_F) ||
                  (c >= iatc_pkg::CHAR_UP_A && c <= iatc_pkg::CHAR_UP_F);
      if (c == iatc_pkg::CHAR_DOT || c == iatc_pkg::CHAR_COLON) begin
        // separator closes the current group
        if (at_start) begin
          dec_ok = 1'b0;
          hex_ok = 1'b0;
        end
        if (c == iatc_pkg::CHAR_DOT) begin
          seen_dot = 1'b1;
          if (octet_ok()) dec_groups = bump(dec_groups);
        end else begin
          seen_colon = 1'b1;
          if (hextet_ok()) hex_groups = bump(hex_groups);
        end
        sep_count = bump(sep_count);
        clear_group();
      end else if (is_digit || is_letter) begin
        if (grp_len == 3'd0 && c == iatc_pkg::CHAR_ZERO) lead_zero = 1'b1;
        if (grp_len < iatc_pkg::LEN_SAT) grp_len = grp_len + 3'd1;
        if (is_digit) begin
          v = int'(grp_val) * 10 + int'(c - iatc_pkg::CHAR_ZERO);
          grp_val = (v > int'(iatc_pkg::VALUE_SAT)) ? iatc_pkg::VALUE_SAT : 10'(v);
        end else begin
          dec_ok = 1'b0;
        end
      end else begin
        // foreign character kills both readings
        dec_ok = 1'b0;
        hex_ok = 1'b0;
      end
      at_start = 1'b0;
      if (last) begin
        // close the final group and classify
        dg  = octet_ok() ? bump(dec_groups) : dec_groups;
        hg  = hextet_ok() ? bump(hex_groups) : hex_groups;
        cls = iatc_pkg::CLS_NONE;
        if (dec_ok && seen_dot && !seen_colon && dg == iatc_pkg::DEC_GROUPS &&
            sep_count == iatc_pkg::DEC_SEPS)
          cls = iatc_pkg::CLS_IPV4;
        else if (hex_ok && seen_colon && !seen_dot && hg == iatc_pkg::HEX_GROUPS &&
                 sep_count == iatc_pkg::HEX_SEPS)
          cls = iatc_pkg::CLS_IPV6;
        expected_classes = {expected_classes, cls};
        clear_string();
      end
    endfunction

    // One accepted result beat
    function void check_class(logic [1:0] act);
      iatc_pkg::addr_class_e exp_cls;
      if (expected_classes.size() == 0) begin
        errors++;
        $display("%0t: unexpected address_class beat: expected none actual %0d", $time, act);
      end else begin
        exp_cls = expected_classes.pop_front();
        if (act !== exp_cls) begin
          errors++;
          $display("%0t: address_class mismatch: expected %0d actual %0d",
                   $time, exp_cls, act);
        end
      end
    endfunction

    function void check_drained();
      if (expected_classes.size() != 0) begin
        errors++;
        $display("%0t: address_class missing: expected %0d more beats actual 0",
                 $time, expected_classes.size());
      end
    endfunction

    function int pending();
      return expected_classes.size();
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] char_code_i;
  logic       last_char_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [1:0] address_class_o;

  addr_class_tracker tracker = new();
  logic [7:0]        text[$];
  int                chars_sent;
  int                stall_left;
  int                cycle_cnt;
  bit                quiet;

  ip_address_text_classifier_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .char_code_i     (char_code_i),
    .last_char_i     (last_char_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .address_class_o (address_class_o)
  );

  // Clock
  always begin
    clk_i = 1'b1;
    #CLK_HALF;
    clk_i = 1'b0;
    #CLK_HALF;
  end

  // Run-length guard
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("ip_address_text_classifier_core verification failed");
      $finish;
    end
  end

  function automatic int draw_wait();
    return quiet ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // Beat monitor: inputs feed the predictor, results are checked
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) tracker.note_char(char_code_i, last_char_i);
      if (out_valid_o && !out_stall_i) begin
        tracker.check_class(address_class_o);
        stall_left = draw_wait();
      end
    end
  end

  // Result-side backpressure
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Drive one character; called and returns at a falling edge
  task automatic send_char(logic [7:0] c, logic last);
    int gap;
    gap = draw_wait();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    last_char_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    chars_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text();
    foreach (text[i]) send_char(text[i], i == text.size() - 1);
  endtask

  task automatic send_str(string s);
    text.delete();
    for (int i = 0; i < s.len(); i++) text = {text, s[i]};
    send_text();
  endtask

  // Hold the sender until every class has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk_i);
  endtask

  function automatic logic [7:0] hex_char(int v, bit upper);
    if (v < 10) return iatc_pkg::CHAR_ZERO + 8'(v);
    return (upper ? iatc_pkg::CHAR_UP_A : iatc_pkg::CHAR_LOW_A) + 8'(v - 10);
  endfunction

  // Any interesting character: separators, digits, hex letters, arbitrary bytes
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 4))
      0:       return iatc_pkg::CHAR_DOT;
      1:       return iatc_pkg::CHAR_COLON;
      2:       return iatc_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
      3:       return hex_char($urandom_range(10, 15), $urandom_range(0, 1));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_decimal(int v);
    if (v >= 100) text = {text, iatc_pkg::CHAR_ZERO + 8'(v / 100)};
    if (v >= 10) text = {text, iatc_pkg::CHAR_ZERO + 8'((v / 10) % 10)};
    text = {text, iatc_pkg::CHAR_ZERO + 8'(v % 10)};
  endtask

  task automatic build_ipv4(bit mangle);
    int v;
    int groups;
    groups = (mangle && $urandom_range(0, 3) == 0) ? $urandom_range(3, 5) : 4;
    for (int g = 0; g < groups; g++) begin
      if (g != 0) text = {text, iatc_pkg::CHAR_DOT};
      case ($urandom_range(0, 4))
        0:       v = $urandom_range(0, 9);
        1:       v = $urandom_range(10, 99);
        2:       v = $urandom_range(100, 255);
        3:       v = mangle ? $urandom_range(256, 999) : 255;
        default: v = $urandom_range(0, 255);
      endcase
      if (mangle && $urandom_range(0, 5) == 0) text = {text, iatc_pkg::CHAR_ZERO};
      push_decimal(v);
    end
  endtask

  task automatic build_ipv6(bit mangle);
    int len;
    for (int g = 0; g < 8; g++) begin
      if (g != 0) text = {text, iatc_pkg::CHAR_COLON};
      len = (mangle && $urandom_range(0, 5) == 0) ? $urandom_range(0, 6) : $urandom_range(1, 4);
      repeat (len) text = {text, hex_char($urandom_range(0, 15), $urandom_range(0, 1))};
    end
  endtask

  // Replace, drop or insert one character
  task automatic mutate();
    int pos;
    pos = $urandom_range(0, text.size() - 1);
    case ($urandom_range(0, 2))
      0:       text[pos] = pick_char();
      1:       text.delete(pos);
      default: text.insert(pos, pick_char());
    endcase
    if (text.size() == 0) text = {text, iatc_pkg::CHAR_ZERO};
  endtask

  task automatic build_long();
    int n;
    n = $urandom_range(14, 22);
    if ($urandom_range(0, 1) == 0) begin
      // many short groups can push the tallies into saturation
      repeat (n) begin
        text = {text, iatc_pkg::CHAR_ZERO + 8'($urandom_range(1, 9))};
        text = {text, ($urandom_range(0, 1) == 0) ? iatc_pkg::CHAR_DOT : iatc_pkg::CHAR_COLON};
      end
      text = {text, iatc_pkg::CHAR_ZERO + 8'($urandom_range(1, 9))};
    end else begin
      // one overlong group
      repeat (n / 2) text = {text, iatc_pkg::CHAR_ZERO + 8'($urandom_range(1, 9))};
      repeat (3) begin
        text = {text, iatc_pkg::CHAR_DOT};
        text = {text, iatc_pkg::CHAR_ZERO + 8'($urandom_range(1, 9))};
      end
    end
  endtask

  // Stimulus
  initial begin
    int kind;
    int len;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    char_code_i = 8'h00;
    last_char_i = 1'b0;
    out_stall_i = 1'b0;
    stall_left  = 0;
    cycle_cnt   = 0;
    chars_sent  = 0;
    quiet       = 1'b0;
    repeat (RESET_CYC) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: valid forms, group limits, separator misuse, foreign characters
    send_str("192.168.1.1");
    send_str("255.255.255.255");
    send_str("0.0.0.0");
    send_str("256.1.1.1");
    send_str("01.2.3.4");
    send_str("1.2.3");
    send_str("1.2.3.4.5");
    send_str("1..2.3");
    send_str(".1.2.3");
    send_str("1.2.3.4:");
    send_str("12345");
    send_str("1.2.3.a");
    send_str("1.2 .3.4");
    send_str("2001:db8:0:0:0:0:0:1");
    send_str("FFFF:ABCD:ef01:0000:1:2:3:4");
    send_str("1::2:3:4:5:6:7");
    send_str(":1:2:3:4:5:6:7");
    send_str("12345:1:2:3:4:5:6:7");
    send_str("1:2:3:4:5:6:7:8:9");
    send_str("1:2:3:4:5:6:7:g");
    send_str("1.2.3................4");
    send_str("99999999999.1.1.1");
    send_str("0");
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
    drain();

    // Random: mostly well-formed addresses, some mangled, some noise
    while (chars_sent < RAND_CHARS) begin
      quiet = ($urandom_range(0, 5) == 0);
      kind  = $urandom_range(0, 99);
      text.delete();
      if (kind < 45) begin
        build_ipv4($urandom_range(0, 3) == 0);
      end else if (kind < 85) begin
        build_ipv6($urandom_range(0, 3) == 0);
      end else if (kind < 95) begin
        len = $urandom_range(1, 12);
        repeat (len) text = {text, pick_char()};
      end else begin
        build_long();
      end
      if (kind < 85 && $urandom_range(0, 3) == 0) mutate();
      if ($urandom_range(0, 49) == 0) drain();
      send_text();
    end

    // Wind down
    in_valid_i <= 1'b0;
    quiet = 1'b1;
    while (tracker.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYC) @(negedge clk_i);
    tracker.check_drained();
    if (tracker.errors == 0) begin
      $display("ip_address_text_classifier_core verification clean");
    end else begin
      $display("ip_address_text_classifier_core verification failed");
    end
    $finish;
  end

endmodule
